// File: rtl/core/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the subarray-sum pair counter.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int MAX_LEN_A_DEF = 32;
  localparam int MAX_LEN_B_DEF = 32;
  localparam int ELEM_W        = 24;
  localparam int SUM_W         = 30;
  localparam int TGT_W         = 32;
  localparam int CNT_OUT_W     = 19;
  localparam logic [CNT_OUT_W-1:0] COUNT_MAX = '1;

  localparam logic REQ_A = 1'b0;
  localparam logic REQ_B = 1'b1;

  typedef enum logic [4:0] {
    ST_LOAD_A,
    ST_LOAD_B,
    ST_START,
    ST_BLD_RD,
    ST_BLD_WR,
    ST_SRT_TOP,
    ST_SRT_RDX,
    ST_SRT_X,
    ST_SRT_CHK,
    ST_SRT_CMP,
    ST_SCN_RD,
    ST_SCN_CMP,
    ST_RUNA,
    ST_RUNA_C,
    ST_RUNB,
    ST_RUNB_C,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } ssp_state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_ADD,
    ACC_CLR
  } ssp_acc_op_t;

  typedef enum logic [1:0] {
    WSRC_ACC,
    WSRC_X,
    WSRC_RD
  } ssp_wsrc_t;

  typedef struct packed {
    logic        elem_we_a;
    logic        elem_we_b;
    ssp_acc_op_t acc_op;
    logic        sum_we;
    logic        sum_sel;
    ssp_wsrc_t   wsrc;
    logic        x_ld;
    logic        run_ld;
    logic        ra_inc;
    logic        rb_inc;
    logic        mul_ld;
    logic        total_add;
    logic        total_clr;
  } ssp_cmd_t;

  typedef struct packed {
    logic sort_gt;
    logic scan_eq;
    logic scan_lt;
    logic run_a_eq;
    logic run_b_eq;
  } ssp_sts_t;

endpackage

// File: rtl/core/ssp_in_if.sv
// ----------------------------------------------------------------------------
// ssp_in_if
// Element request channel: valid/ready with one array element.
// ----------------------------------------------------------------------------
interface ssp_in_if;
  import ssp_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ELEM_W-1:0] element_value;
  logic              last_element;

  modport source (output valid, output req_type, output element_value,
                  output last_element, input ready);
  modport sink   (input valid, input req_type, input element_value,
                  input last_element, output ready);
endinterface

// File: rtl/core/ssp_out_if.sv
// ----------------------------------------------------------------------------
// ssp_out_if
// Result request channel: valid/ready with the pair count.
// ----------------------------------------------------------------------------
interface ssp_out_if;
  import ssp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CNT_OUT_W-1:0] pair_count;

  modport source (output valid, output pair_count, input ready);
  modport sink   (input valid, input pair_count, output ready);
endinterface

// File: rtl/core/subarray_sum_pair_counter_core.sv
// ----------------------------------------------------------------------------
// subarray_sum_pair_counter_core
// Counts pairs of subarray sums of A and B that total the target value.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    req_type, element_value, last_element
// out_ch   out  valid/ready    pair_count
// cfg      in   cfg_we         cfg_wdata (target sum)
//
// Elements load at one per cycle. After the last B element the sequencer
// builds both sum lists, insertion-sorts each in its own sum memory, then
// scans the two sorted lists with two pointers; each list memory gives one
// read per cycle.
// Input stalls during that work; the result waits in a register and the
// next A array loads meanwhile. Synchronous active-low reset, no clear pass.
// ----------------------------------------------------------------------------
module subarray_sum_pair_counter_core #(
  parameter int MAX_LEN_A = ssp_pkg::MAX_LEN_A_DEF,
  parameter int MAX_LEN_B = ssp_pkg::MAX_LEN_B_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ssp_in_if.sink                    in_ch,
  ssp_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [ssp_pkg::TGT_W-1:0] cfg_wdata
);
  import ssp_pkg::*;

  localparam int MAX_LEN_MX = (MAX_LEN_A > MAX_LEN_B) ? MAX_LEN_A : MAX_LEN_B;
  localparam int SDEP_MX    = MAX_LEN_MX * (MAX_LEN_MX + 1) / 2;
  localparam int LEN_W      = $clog2(MAX_LEN_MX + 1);
  localparam int CNT_W      = $clog2(SDEP_MX + 1);

  ssp_cmd_t         cmd;
  ssp_sts_t         sts;
  logic [LEN_W-1:0] elem_waddr, elem_raddr;
  logic [CNT_W-1:0] sum_waddr, sum_raddr_a, sum_raddr_b;

  ssp_ctrl #(
    .MAX_LEN_A (MAX_LEN_A),
    .MAX_LEN_B (MAX_LEN_B),
    .LEN_W     (LEN_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_req_type     (in_ch.req_type),
    .in_last_element (in_ch.last_element),
    .in_ready        (in_ch.ready),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .cmd             (cmd),
    .sts             (sts),
    .elem_waddr      (elem_waddr),
    .elem_raddr      (elem_raddr),
    .sum_waddr       (sum_waddr),
    .sum_raddr_a     (sum_raddr_a),
    .sum_raddr_b     (sum_raddr_b)
  );

  ssp_datapath #(
    .MAX_LEN_A (MAX_LEN_A),
    .MAX_LEN_B (MAX_LEN_B),
    .LEN_W     (LEN_W),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .elem_waddr  (elem_waddr),
    .elem_raddr  (elem_raddr),
    .elem_wdata  (in_ch.element_value),
    .sum_waddr   (sum_waddr),
    .sum_raddr_a (sum_raddr_a),
    .sum_raddr_b (sum_raddr_b),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .pair_count  (out_ch.pair_count)
  );

endmodule

// File: rtl/core/ssp_datapath.sv
// ----------------------------------------------------------------------------
// ssp_datapath
// Element and sum memories, accumulator, comparators and pair counter.
// ----------------------------------------------------------------------------
module ssp_datapath #(
  parameter int MAX_LEN_A = ssp_pkg::MAX_LEN_A_DEF,
  parameter int MAX_LEN_B = ssp_pkg::MAX_LEN_B_DEF,
  parameter int LEN_W     = 6,
  parameter int CNT_W     = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssp_pkg::ssp_cmd_t            cmd,
  output ssp_pkg::ssp_sts_t            sts,
  input  logic [LEN_W-1:0]             elem_waddr,
  input  logic [LEN_W-1:0]             elem_raddr,
  input  logic [ssp_pkg::ELEM_W-1:0]   elem_wdata,
  input  logic [CNT_W-1:0]             sum_waddr,
  input  logic [CNT_W-1:0]             sum_raddr_a,
  input  logic [CNT_W-1:0]             sum_raddr_b,
  input  logic                         cfg_we,
  input  logic [ssp_pkg::TGT_W-1:0]    cfg_wdata,
  output logic [ssp_pkg::CNT_OUT_W-1:0] pair_count
);
  import ssp_pkg::*;

  localparam int SDEP_A = MAX_LEN_A * (MAX_LEN_A + 1) / 2;
  localparam int SDEP_B = MAX_LEN_B * (MAX_LEN_B + 1) / 2;
  localparam int EA_AW  = (MAX_LEN_A > 1) ? $clog2(MAX_LEN_A) : 1;
  localparam int EB_AW  = (MAX_LEN_B > 1) ? $clog2(MAX_LEN_B) : 1;
  localparam int SA_AW  = (SDEP_A > 1) ? $clog2(SDEP_A) : 1;
  localparam int SB_AW  = (SDEP_B > 1) ? $clog2(SDEP_B) : 1;
  localparam int PROD_W = 2 * CNT_W;
  localparam int TOT_W  = ((PROD_W > CNT_OUT_W) ? PROD_W : CNT_OUT_W) + 1;

  logic signed [ELEM_W-1:0] elems_a [MAX_LEN_A];
  logic signed [ELEM_W-1:0] elems_b [MAX_LEN_B];
  logic signed [SUM_W-1:0]  sums_a  [SDEP_A];
  logic signed [SUM_W-1:0]  sums_b  [SDEP_B];

  logic signed [ELEM_W-1:0] ea_rd_r, eb_rd_r;
  logic signed [SUM_W-1:0]  sa_rd_r, sb_rd_r;
  logic signed [SUM_W-1:0]  acc_r, x_r, va_r, vb_r;
  logic [CNT_W-1:0]         ra_r, rb_r;
  logic [PROD_W-1:0]        prod_r;
  logic [CNT_OUT_W-1:0]     total_r, total_nxt;
  logic signed [TGT_W-1:0]  target_r;

  logic signed [ELEM_W-1:0] el_rd;
  logic signed [SUM_W-1:0]  s_rd, acc_sum, wdata;
  logic signed [TGT_W-1:0]  pair_sum;
  logic [TOT_W-1:0]         tot_sum;

  assign el_rd    = cmd.sum_sel ? eb_rd_r : ea_rd_r;
  assign s_rd     = cmd.sum_sel ? sb_rd_r : sa_rd_r;
  assign acc_sum  = acc_r + SUM_W'(el_rd);
  assign pair_sum = TGT_W'(sa_rd_r) + TGT_W'(sb_rd_r);
  assign tot_sum  = TOT_W'(total_r) + TOT_W'(prod_r);

  always_comb begin
    case (cmd.wsrc)
      WSRC_ACC: wdata = acc_sum;
      WSRC_X:   wdata = x_r;
      WSRC_RD:  wdata = s_rd;
      default:  wdata = acc_sum;
    endcase
  end

  always_comb begin
    total_nxt = total_r;
    if (cmd.total_clr) begin
      total_nxt = '0;
    end else if (cmd.total_add) begin
      total_nxt = (tot_sum > TOT_W'(COUNT_MAX)) ? COUNT_MAX : tot_sum[CNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.elem_we_a) begin
      elems_a[elem_waddr[EA_AW-1:0]] <= elem_wdata;
    end
    if (cmd.elem_we_b) begin
      elems_b[elem_waddr[EB_AW-1:0]] <= elem_wdata;
    end
    ea_rd_r <= elems_a[elem_raddr[EA_AW-1:0]];
    eb_rd_r <= elems_b[elem_raddr[EB_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_we && !cmd.sum_sel) begin
      sums_a[sum_waddr[SA_AW-1:0]] <= wdata;
    end
    if (cmd.sum_we && cmd.sum_sel) begin
      sums_b[sum_waddr[SB_AW-1:0]] <= wdata;
    end
    sa_rd_r <= sums_a[sum_raddr_a[SA_AW-1:0]];
    sb_rd_r <= sums_b[sum_raddr_b[SB_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_ADD:  acc_r <= acc_sum;
      ACC_CLR:  acc_r <= '0;
      default:  acc_r <= acc_r;
    endcase
    if (cmd.x_ld) begin
      x_r <= s_rd;
    end
    if (cmd.run_ld) begin
      va_r <= sa_rd_r;
      vb_r <= sb_rd_r;
      ra_r <= CNT_W'(1);
      rb_r <= CNT_W'(1);
    end else begin
      if (cmd.ra_inc) begin
        ra_r <= ra_r + 1'b1;
      end
      if (cmd.rb_inc) begin
        rb_r <= rb_r + 1'b1;
      end
    end
    if (cmd.mul_ld) begin
      prod_r <= ra_r * rb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      total_r  <= '0;
    end else begin
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
      total_r <= total_nxt;
    end
  end

  assign sts.sort_gt  = s_rd > x_r;
  assign sts.scan_eq  = pair_sum == target_r;
  assign sts.scan_lt  = pair_sum < target_r;
  assign sts.run_a_eq = sa_rd_r == va_r;
  assign sts.run_b_eq = sb_rd_r == vb_r;

  assign pair_count = total_r;

endmodule

// File: rtl/core/ssp_ctrl.sv
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer: load, build sums, insertion sort, two-pointer scan, result.
// ----------------------------------------------------------------------------
module ssp_ctrl #(
  parameter int MAX_LEN_A = ssp_pkg::MAX_LEN_A_DEF,
  parameter int MAX_LEN_B = ssp_pkg::MAX_LEN_B_DEF,
  parameter int LEN_W     = 6,
  parameter int CNT_W     = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  input  logic              in_last_element,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output ssp_pkg::ssp_cmd_t cmd,
  input  ssp_pkg::ssp_sts_t sts,
  output logic [LEN_W-1:0]  elem_waddr,
  output logic [LEN_W-1:0]  elem_raddr,
  output logic [CNT_W-1:0]  sum_waddr,
  output logic [CNT_W-1:0]  sum_raddr_a,
  output logic [CNT_W-1:0]  sum_raddr_b
);
  import ssp_pkg::*;

  localparam int SDEP_A = MAX_LEN_A * (MAX_LEN_A + 1) / 2;
  localparam int SDEP_B = MAX_LEN_B * (MAX_LEN_B + 1) / 2;

  ssp_state_t       state_r, state_nxt;
  logic [LEN_W-1:0] len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic [LEN_W-1:0] bi_r, bi_nxt, bj_r, bj_nxt;
  logic [CNT_W-1:0] k_r, k_nxt, si_r, si_nxt, sj_r, sj_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, na_r, na_nxt, nb_r, nb_nxt;
  logic             sel_r, sel_nxt, out_valid_r, out_valid_nxt;

  logic             acc;
  logic [LEN_W-1:0] n_len;
  logic [CNT_W-1:0] n_sum;
  logic             row_end, list_end;

  assign acc      = in_valid && in_ready;
  assign n_len    = sel_r ? len_b_r : len_a_r;
  assign n_sum    = sel_r ? nb_r : na_r;
  assign row_end  = (bj_r + 1'b1) == n_len;
  assign list_end = (bi_r + 1'b1) == n_len;
  assign in_ready  = (state_r == ST_LOAD_A) || (state_r == ST_LOAD_B);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD_A:  if (acc && in_req_type == REQ_A && in_last_element) begin
                    state_nxt = ST_LOAD_B;
                  end
      ST_LOAD_B:  if (acc && in_req_type == REQ_B && in_last_element) begin
                    state_nxt = ST_START;
                  end
      ST_START:   if (!out_valid_r) begin
                    state_nxt = ST_BLD_RD;
                  end
      ST_BLD_RD:  state_nxt = ST_BLD_WR;
      ST_BLD_WR:  if (row_end && list_end && sel_r) begin
                    state_nxt = ST_SRT_TOP;
                  end else begin
                    state_nxt = ST_BLD_RD;
                  end
      ST_SRT_TOP: if (si_r >= n_sum) begin
                    if (sel_r) begin
                      state_nxt = ST_SCN_RD;
                    end
                  end else begin
                    state_nxt = ST_SRT_RDX;
                  end
      ST_SRT_RDX: state_nxt = ST_SRT_X;
      ST_SRT_X:   state_nxt = ST_SRT_CHK;
      ST_SRT_CHK: if (sj_r == '0) begin
                    state_nxt = ST_SRT_TOP;
                  end else begin
                    state_nxt = ST_SRT_CMP;
                  end
      ST_SRT_CMP: if (sts.sort_gt) begin
                    state_nxt = ST_SRT_CHK;
                  end else begin
                    state_nxt = ST_SRT_TOP;
                  end
      ST_SCN_RD:  if (lo_r >= na_r || hi_r == '0) begin
                    state_nxt = ST_DONE;
                  end else begin
                    state_nxt = ST_SCN_CMP;
                  end
      ST_SCN_CMP: if (sts.scan_eq) begin
                    state_nxt = ST_RUNA;
                  end else begin
                    state_nxt = ST_SCN_RD;
                  end
      ST_RUNA:    if ((lo_r + 1'b1) < na_r) begin
                    state_nxt = ST_RUNA_C;
                  end else begin
                    state_nxt = ST_RUNB;
                  end
      ST_RUNA_C:  if (sts.run_a_eq) begin
                    state_nxt = ST_RUNA;
                  end else begin
                    state_nxt = ST_RUNB;
                  end
      ST_RUNB:    if (hi_r > CNT_W'(1)) begin
                    state_nxt = ST_RUNB_C;
                  end else begin
                    state_nxt = ST_MUL;
                  end
      ST_RUNB_C:  if (sts.run_b_eq) begin
                    state_nxt = ST_RUNB;
                  end else begin
                    state_nxt = ST_MUL;
                  end
      ST_MUL:     state_nxt = ST_ADD;
      ST_ADD:     state_nxt = ST_SCN_RD;
      ST_DONE:    state_nxt = ST_LOAD_A;
      default:    state_nxt = ST_LOAD_A;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.acc_op    = ACC_HOLD;
    cmd.wsrc      = WSRC_ACC;
    cmd.sum_sel   = sel_r;
    elem_waddr    = '0;
    elem_raddr    = bj_r;
    sum_waddr     = '0;
    sum_raddr_a   = '0;
    sum_raddr_b   = '0;
    len_a_nxt     = len_a_r;
    len_b_nxt     = len_b_r;
    bi_nxt        = bi_r;
    bj_nxt        = bj_r;
    k_nxt         = k_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_LOAD_A: begin
        elem_waddr = len_a_r;
        if (acc && in_req_type == REQ_A && len_a_r < LEN_W'(MAX_LEN_A)) begin
          cmd.elem_we_a = 1'b1;
          len_a_nxt     = len_a_r + 1'b1;
        end
      end
      ST_LOAD_B: begin
        elem_waddr = len_b_r;
        if (acc && in_req_type == REQ_B && len_b_r < LEN_W'(MAX_LEN_B)) begin
          cmd.elem_we_b = 1'b1;
          len_b_nxt     = len_b_r + 1'b1;
        end
      end
      ST_START: begin
        if (!out_valid_r) begin
          cmd.total_clr = 1'b1;
          cmd.acc_op    = ACC_CLR;
          sel_nxt       = 1'b0;
          k_nxt         = '0;
          bi_nxt        = '0;
          bj_nxt        = '0;
        end
      end
      ST_BLD_WR: begin
        cmd.sum_we = 1'b1;
        sum_waddr  = k_r;
        k_nxt      = k_r + 1'b1;
        if (row_end) begin
          cmd.acc_op = ACC_CLR;
          if (list_end) begin
            bi_nxt = '0;
            bj_nxt = '0;
            if (!sel_r) begin
              na_nxt  = k_r + 1'b1;
              sel_nxt = 1'b1;
              k_nxt   = '0;
            end else begin
              nb_nxt  = k_r + 1'b1;
              sel_nxt = 1'b0;
              si_nxt  = CNT_W'(1);
            end
          end else begin
            bi_nxt = bi_r + 1'b1;
            bj_nxt = bi_r + 1'b1;
          end
        end else begin
          cmd.acc_op = ACC_ADD;
          bj_nxt     = bj_r + 1'b1;
        end
      end
      ST_SRT_TOP: begin
        if (si_r >= n_sum) begin
          if (!sel_r) begin
            sel_nxt = 1'b1;
            si_nxt  = CNT_W'(1);
          end else begin
            sel_nxt = 1'b0;
            lo_nxt  = '0;
            hi_nxt  = nb_r;
          end
        end
      end
      ST_SRT_RDX: begin
        sum_raddr_a = si_r;
        sum_raddr_b = si_r;
      end
      ST_SRT_X: begin
        cmd.x_ld = 1'b1;
        sj_nxt   = si_r;
      end
      ST_SRT_CHK: begin
        sum_raddr_a = sj_r - 1'b1;
        sum_raddr_b = sj_r - 1'b1;
        if (sj_r == '0) begin
          cmd.sum_we = 1'b1;
          cmd.wsrc   = WSRC_X;
          sum_waddr  = sj_r;
          si_nxt     = si_r + 1'b1;
        end
      end
      ST_SRT_CMP: begin
        cmd.sum_we = 1'b1;
        sum_waddr  = sj_r;
        if (sts.sort_gt) begin
          cmd.wsrc = WSRC_RD;
          sj_nxt   = sj_r - 1'b1;
        end else begin
          cmd.wsrc = WSRC_X;
          si_nxt   = si_r + 1'b1;
        end
      end
      ST_SCN_RD: begin
        sum_raddr_a = lo_r;
        sum_raddr_b = hi_r - 1'b1;
      end
      ST_SCN_CMP: begin
        if (sts.scan_eq) begin
          cmd.run_ld = 1'b1;
        end else if (sts.scan_lt) begin
          lo_nxt = lo_r + 1'b1;
        end else begin
          hi_nxt = hi_r - 1'b1;
        end
      end
      ST_RUNA: begin
        sum_raddr_a = lo_r + 1'b1;
      end
      ST_RUNA_C: begin
        if (sts.run_a_eq) begin
          cmd.ra_inc = 1'b1;
          lo_nxt     = lo_r + 1'b1;
        end
      end
      ST_RUNB: begin
        sum_raddr_b = hi_r - CNT_W'(2);
      end
      ST_RUNB_C: begin
        if (sts.run_b_eq) begin
          cmd.rb_inc = 1'b1;
          hi_nxt     = hi_r - 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul_ld = 1'b1;
      end
      ST_ADD: begin
        cmd.total_add = 1'b1;
        lo_nxt        = lo_r + 1'b1;
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        len_a_nxt     = '0;
        len_b_nxt     = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD_A;
      len_a_r     <= '0;
      len_b_r     <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bi_r <= bi_nxt;
    bj_r <= bj_nxt;
    k_r  <= k_nxt;
    si_r <= si_nxt;
    sj_r <= sj_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    na_r <= na_nxt;
    nb_r <= nb_nxt;
  end

`ifndef NO_ASSERTIONS
  a_len_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_a_r <= LEN_W'(MAX_LEN_A))
    else $error("len_a overflow");
  a_len_b_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_b_r <= LEN_W'(MAX_LEN_B))
    else $error("len_b overflow");
  a_start_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START && out_valid_r) |=> state_r == ST_START)
    else $error("compute started with result pending");
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCN_CMP |-> (lo_r < na_r && hi_r != '0 && hi_r <= nb_r))
    else $error("scan pointers out of range");
  a_sum_waddr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum_we |-> (sel_r ? (sum_waddr < CNT_W'(SDEP_B)) : (sum_waddr < CNT_W'(SDEP_A))))
    else $error("sum write beyond list");
`endif

endmodule
